// File: src/cpd_pkg.sv
// Package for the closest pair distance unit.
// Holds the result widths, the saturation limit and the structs shared by the submodules.
// Depends on nothing.
package cpd_pkg;

  // Widths of the result fields.
  localparam int SQ_W        = 52;
  localparam int ROOT_W      = 26;
  localparam int ROOT_STEP_W = $clog2(ROOT_W);
  // Remainder of the root recurrence: two bits above the root, plus one for the shift.
  localparam int REM_W       = ROOT_W + 3;

  // Largest representable squared distance; also the start value of the running minimum.
  localparam logic [SQ_W-1:0] SQ_MAX = {SQ_W{1'b1}};

  // Output of the squared distance pipeline.
  typedef struct packed {
    logic            valid;
    logic            busy;
    logic [SQ_W-1:0] sq;
  } dist_res_t;

  // Status and result of the square root unit.
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ROOT_W-1:0] root;
  } root_res_t;

endpackage

// File: src/cpd_in_if.sv
// Input channel of the closest pair distance unit: one point per transaction.
// Depends on nothing; COORD_BITS sets the coordinate width.
interface cpd_in_if #(
  parameter int COORD_BITS = 24
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic                         last_point;

  modport source (output valid, px, py, last_point, input ready);
  modport sink (input valid, px, py, last_point, output ready);
endinterface

// File: src/cpd_out_if.sv
// Result channel of the closest pair distance unit: one result per point set.
// Depends on cpd_pkg for the field widths.
interface cpd_out_if
  import cpd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SQ_W-1:0]   min_dist_sq;
  logic [ROOT_W-1:0] min_dist;
  logic              no_pair;

  modport source (output valid, min_dist_sq, min_dist, no_pair, input ready);
  modport sink (input valid, min_dist_sq, min_dist, no_pair, output ready);
endinterface

// File: src/closest_pair_distance_unit.sv
// Top level of the closest pair distance unit: point store, sequencer, running minimum.
// Depends on cpd_pkg, cpd_in_if, cpd_out_if, cpd_dist and cpd_isqrt.
//
// The unit takes a set of 2-D points, one per input transaction, the last one flagged
// by last_point, and returns one result per set: the exact smallest squared distance
// over all pairs, its floor square root, and no_pair when the set held fewer than two
// points. Each arriving point is compared with every point already stored, one stored
// point per cycle through the pipelined squared distance unit; the single read port of
// the point memory sets this rate. The flagged last point then waits for the iterative
// square root, which consumes two operand bits per cycle. The input is not ready while
// a point is being processed. Points beyond MAX_POINTS in one set are dropped. The
// memory needs no clearing after reset.
module closest_pair_distance_unit
  import cpd_pkg::*;
#(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 24
) (
  input logic    clk,
  input logic    rst_n,
  cpd_in_if.sink in_ch,
  cpd_out_if.source out_ch
);

  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int PT_W   = 2 * COORD_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_STORE,
    S_FIN,
    S_ROOT,
    S_OUT
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [ADDR_W-1:0]            rd_idx_r, rd_idx_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  logic [SQ_W-1:0]              best_r, best_nxt;
  logic signed [COORD_BITS-1:0] cur_x_r, cur_x_nxt;
  logic signed [COORD_BITS-1:0] cur_y_r, cur_y_nxt;
  logic                         cur_last_r, cur_last_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [SQ_W-1:0]              min_dist_sq_r, min_dist_sq_nxt;
  logic [ROOT_W-1:0]            min_dist_r, min_dist_nxt;
  logic                         no_pair_r, no_pair_nxt;

  logic [PT_W-1:0] pt_mem [MAX_POINTS];
  logic [PT_W-1:0] rd_data_r;
  logic            mem_we;
  logic            mem_re;
  logic            in_fire;
  logic            has_pair;
  logic            root_start;
  dist_res_t       dist_res;
  root_res_t       root_res;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign has_pair = (count_r >= CNT_W'(2));

  // Sequencer: one point at a time, stored points streamed through the distance unit.
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    rd_idx_nxt      = rd_idx_r;
    best_nxt        = best_r;
    cur_x_nxt       = cur_x_r;
    cur_y_nxt       = cur_y_r;
    cur_last_nxt    = cur_last_r;
    out_valid_nxt   = out_valid_r;
    min_dist_sq_nxt = min_dist_sq_r;
    min_dist_nxt    = min_dist_r;
    no_pair_nxt     = no_pair_r;
    mem_re          = 1'b0;
    mem_we          = 1'b0;
    root_start      = 1'b0;

    // The result register is emptied when its transaction completes.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // Running minimum over the distances leaving the pipeline.
    if (dist_res.valid && dist_res.sq < best_r) begin
      best_nxt = dist_res.sq;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cur_x_nxt    = in_ch.px;
          cur_y_nxt    = in_ch.py;
          cur_last_nxt = in_ch.last_point;
          rd_idx_nxt   = '0;
          if (count_r == CNT_W'(MAX_POINTS)) begin
            // Store full: the point is dropped.
            state_nxt = in_ch.last_point ? S_FIN : S_IDLE;
          end else if (count_r == '0) begin
            state_nxt = S_STORE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        mem_re     = 1'b1;
        rd_idx_nxt = rd_idx_r + 1'b1;
        if (CNT_W'(rd_idx_r) == count_r - 1'b1) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_vld_r && !dist_res.busy) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        mem_we    = 1'b1;
        count_nxt = count_r + 1'b1;
        state_nxt = cur_last_r ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (has_pair) begin
          root_start = 1'b1;
          state_nxt  = S_ROOT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_ROOT: begin
        if (root_res.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Load the result once the register is free, then start a new set.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          no_pair_nxt     = !has_pair;
          min_dist_sq_nxt = has_pair ? best_r : '0;
          min_dist_nxt    = has_pair ? root_res.root : '0;
          count_nxt       = '0;
          best_nxt        = SQ_MAX;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign rd_vld_nxt = mem_re;

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      best_r      <= SQ_MAX;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_idx_r      <= rd_idx_nxt;
    cur_x_r       <= cur_x_nxt;
    cur_y_r       <= cur_y_nxt;
    cur_last_r    <= cur_last_nxt;
    min_dist_sq_r <= min_dist_sq_nxt;
    min_dist_r    <= min_dist_nxt;
    no_pair_r     <= no_pair_nxt;
  end

  // Point memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pt_mem[count_r[ADDR_W-1:0]] <= {cur_x_r, cur_y_r};
    end
    if (mem_re) begin
      rd_data_r <= pt_mem[rd_idx_r];
    end
  end

  // Squared distance between the new point and each stored point.
  cpd_dist #(
    .COORD_BITS(COORD_BITS)
  ) u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (rd_vld_r),
    .ax_i  (cur_x_r),
    .ay_i  (cur_y_r),
    .bx_i  (rd_data_r[PT_W-1:COORD_BITS]),
    .by_i  (rd_data_r[COORD_BITS-1:0]),
    .res_o (dist_res)
  );

  // Floor square root of the final minimum.
  cpd_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (root_start),
    .operand_i (best_r),
    .res_o     (root_res)
  );

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.min_dist_sq = min_dist_sq_r;
  assign out_ch.min_dist    = min_dist_r;
  assign out_ch.no_pair     = no_pair_r;

`ifndef SYNTH
  // The store never holds more points than it has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POINTS))
    else $error("point count beyond the store depth");

  // Only stored points are read during a scan.
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |-> (CNT_W'(rd_idx_r) < count_r))
    else $error("read of a point that is not stored");

  // A new transaction is taken only when no distance or root is still in flight.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (!dist_res.busy && !rd_vld_r && !root_res.busy))
    else $error("input ready while the datapath is busy");

  // The reported root never overshoots the squared distance.
  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !no_pair_r) |->
      ((SQ_W'(min_dist_r) * SQ_W'(min_dist_r)) <= min_dist_sq_r))
    else $error("square root larger than the distance");
`endif

endmodule

// File: src/cpd_dist.sv
// Pipelined squared distance unit: absolute differences, squares, saturating sum.
// Depends on cpd_pkg. Takes one pair per cycle.
module cpd_dist
  import cpd_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         vld_i,
  input  logic signed [COORD_BITS-1:0] ax_i,
  input  logic signed [COORD_BITS-1:0] ay_i,
  input  logic signed [COORD_BITS-1:0] bx_i,
  input  logic signed [COORD_BITS-1:0] by_i,
  output dist_res_t                    res_o
);

  localparam int PROD_W = 2 * COORD_BITS;
  localparam int SUM_W  = PROD_W + 1;
  localparam int EXT_W  = (SUM_W > SQ_W) ? SUM_W : SQ_W;

  logic signed [COORD_BITS:0] diff_x;
  logic signed [COORD_BITS:0] diff_y;
  logic [COORD_BITS:0]        abs_x;
  logic [COORD_BITS:0]        abs_y;
  logic [SUM_W-1:0]           sum;
  logic [EXT_W-1:0]           sum_ext;
  logic [SQ_W-1:0]            sum_sat;

  logic                  s1_vld_r;
  logic                  s2_vld_r;
  logic                  s3_vld_r;
  logic [COORD_BITS-1:0] dx_r;
  logic [COORD_BITS-1:0] dy_r;
  logic [PROD_W-1:0]     px_r;
  logic [PROD_W-1:0]     py_r;
  logic [SQ_W-1:0]       sq_r;

  // Differences in one extra bit, then their magnitudes, which always fit COORD_BITS bits.
  always_comb begin
    diff_x = {ax_i[COORD_BITS-1], ax_i} - {bx_i[COORD_BITS-1], bx_i};
    diff_y = {ay_i[COORD_BITS-1], ay_i} - {by_i[COORD_BITS-1], by_i};
    abs_x  = diff_x[COORD_BITS] ? (COORD_BITS+1)'(-diff_x) : (COORD_BITS+1)'(diff_x);
    abs_y  = diff_y[COORD_BITS] ? (COORD_BITS+1)'(-diff_y) : (COORD_BITS+1)'(diff_y);
  end

  // Sum of squares, clamped to the largest representable squared distance.
  always_comb begin
    sum     = SUM_W'(px_r) + SUM_W'(py_r);
    sum_ext = EXT_W'(sum);
    sum_sat = (sum_ext > EXT_W'(SQ_MAX)) ? SQ_MAX : sum_ext[SQ_W-1:0];
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= vld_i;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // Data path: magnitudes, then squares, then the clamped sum.
  always_ff @(posedge clk) begin
    dx_r <= abs_x[COORD_BITS-1:0];
    dy_r <= abs_y[COORD_BITS-1:0];
    px_r <= PROD_W'(dx_r) * PROD_W'(dx_r);
    py_r <= PROD_W'(dy_r) * PROD_W'(dy_r);
    sq_r <= sum_sat;
  end

  assign res_o.valid = s3_vld_r;
  assign res_o.busy  = s1_vld_r | s2_vld_r | s3_vld_r;
  assign res_o.sq    = sq_r;

endmodule

// File: src/cpd_isqrt.sv
// Iterative integer square root, two operand bits per cycle.
// Depends on cpd_pkg. After the start pulse the root is built one bit per step, most significant first.
module cpd_isqrt
  import cpd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start_i,
  input  logic [SQ_W-1:0] operand_i,
  output root_res_t       res_o
);

  logic                   busy_r;
  logic                   done_r;
  logic [ROOT_STEP_W-1:0] step_r;
  logic [SQ_W-1:0]        val_r;
  logic [REM_W-1:0]       rem_r;
  logic [ROOT_W-1:0]      root_r;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             take;

  // One step of the digit recurrence: bring in the next two bits and try 4*root+1.
  always_comb begin
    rem_sh = {rem_r[REM_W-3:0], val_r[SQ_W-1 -: 2]};
    trial  = REM_W'({root_r, 2'b01});
    take   = (rem_sh >= trial);
  end

  // Sequencing of the steps and the working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
    if (start_i) begin
      step_r <= ROOT_STEP_W'(ROOT_W - 1);
      val_r  <= operand_i;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r - 1'b1;
      val_r  <= {val_r[SQ_W-3:0], 2'b00};
      rem_r  <= take ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], take};
    end
  end

  assign res_o.busy = busy_r;
  assign res_o.done = done_r;
  assign res_o.root = root_r;

endmodule
